// ===== rtl/kme_pkg.sv =====
// Shared constants for the Kruskal maze edge merger: field widths, codes and defaults.
// No dependencies; kme_ctrl and the top level in rtl/ import this package.
`timescale 1ns / 1ps

package kme_pkg;

  // Default grid limits.
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  // Field widths of the transaction ports.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int WALL_W = 7;
  localparam int CFG_W  = 6;
  localparam int CFG_IDX_W = 1;

  // Register reset values.
  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // Operation and direction codes.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_EDGE    = 1'b1;
  localparam logic DIR_RIGHT  = 1'b0;
  localparam logic DIR_DOWN   = 1'b1;

endpackage

// ===== rtl/kme_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module kme_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/kme_ctrl.sv =====
// Sequencer of the maze edge merger: label fill, edge lookup and relabel scan.
// Depends on kme_pkg; drives the label RAM (kme_ram) owned by the top level.
`timescale 1ns / 1ps

module kme_ctrl #(
  parameter int MAX_ROWS = kme_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kme_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_operation,
  input  logic [kme_pkg::ROW_W-1:0]              in_cell_row,
  input  logic [kme_pkg::COL_W-1:0]              in_cell_col,
  input  logic                                   in_direction,
  input  logic [$clog2(MAX_ROWS+1)-1:0]          num_rows,
  input  logic [$clog2(MAX_COLS+1)-1:0]          num_cols,
  output logic                                   out_valid,
  output logic                                   out_carved,
  output logic                                   out_rejected,
  output logic [kme_pkg::WALL_W-1:0]             out_wall_row,
  output logic [kme_pkg::WALL_W-1:0]             out_wall_col,
  output logic                                   mem_we,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   mem_waddr,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   mem_wdata,
  output logic                                   mem_re,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   mem_raddr,
  input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   mem_rdata
);

  import kme_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int NRW    = $clog2(MAX_ROWS + 1);
  localparam int NCW    = $clog2(MAX_COLS + 1);
  localparam int RCMP_W = (NRW > ROW_W + 1) ? NRW : ROW_W + 1;
  localparam int CCMP_W = (NCW > COL_W + 1) ? NCW : COL_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_COLS);

  // State codes.
  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDA   = 3'd2;
  localparam logic [2:0] S_RDB   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] fill_addr_r, fill_addr_nxt;
  logic              fill_res_r, fill_res_nxt;
  logic [ADDR_W-1:0] addr_a_r, addr_a_nxt;
  logic [ADDR_W-1:0] addr_b_r, addr_b_nxt;
  logic [WALL_W-1:0] wall_row_r, wall_row_nxt;
  logic [WALL_W-1:0] wall_col_r, wall_col_nxt;
  logic [ADDR_W-1:0] label_a_r, label_a_nxt;
  logic [ADDR_W-1:0] label_b_r, label_b_nxt;
  logic [RW-1:0]     scan_row_r, scan_row_nxt;
  logic [CW-1:0]     scan_col_r, scan_col_nxt;
  logic [ADDR_W-1:0] scan_base_r, scan_base_nxt;
  logic              pipe_vld_r, pipe_vld_nxt;
  logic [ADDR_W-1:0] pipe_addr_r, pipe_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_carved_r, out_carved_nxt;
  logic              out_rejected_r, out_rejected_nxt;
  logic [WALL_W-1:0] out_wall_row_r, out_wall_row_nxt;
  logic [WALL_W-1:0] out_wall_col_r, out_wall_col_nxt;

  logic [ROW_W:0]    nbr_row;
  logic [COL_W:0]    nbr_col;
  logic              in_grid;
  logic              accept;
  logic [ADDR_W-1:0] in_addr_a;
  logic [ADDR_W-1:0] in_addr_b;
  logic [ADDR_W-1:0] scan_addr;
  logic              scan_last_col;
  logic              scan_last_row;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Neighbor cell and grid check; the neighbor is never above or left of the first cell.
  assign nbr_row = {1'b0, in_cell_row} + {{ROW_W{1'b0}}, in_direction == DIR_DOWN};
  assign nbr_col = {1'b0, in_cell_col} + {{COL_W{1'b0}}, in_direction == DIR_RIGHT};
  assign in_grid = (RCMP_W'(nbr_row) < RCMP_W'(num_rows)) &&
                   (CCMP_W'(nbr_col) < CCMP_W'(num_cols));

  // Linear cell addresses, row-major with a fixed row pitch.
  assign in_addr_a = ADDR_W'(in_cell_row) * ROW_STEP + ADDR_W'(in_cell_col);
  assign in_addr_b = ADDR_W'(nbr_row) * ROW_STEP + ADDR_W'(nbr_col);

  assign scan_addr     = scan_base_r + ADDR_W'(scan_col_r);
  assign scan_last_col = (NCW'(scan_col_r) == num_cols - NCW'(1));
  assign scan_last_row = (NRW'(scan_row_r) == num_rows - NRW'(1));

  // Write port: label fill, and write-back of the relabel scan in the cycle after its read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pipe_addr_r;
    mem_wdata = label_a_r;
    if (state_r == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr_r;
      mem_wdata = fill_addr_r;
    end else if (pipe_vld_r && (mem_rdata == label_b_r)) begin
      mem_we = 1'b1;
    end
  end

  // Read address by state.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = scan_addr;
    case (state_r)
      S_RDA: begin
        mem_re    = 1'b1;
        mem_raddr = addr_a_r;
      end
      S_RDB: begin
        mem_re    = 1'b1;
        mem_raddr = addr_b_r;
      end
      S_SCAN: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Next-state logic of the sequencer and the result register.
  always_comb begin
    state_nxt        = state_r;
    fill_addr_nxt    = fill_addr_r;
    fill_res_nxt     = fill_res_r;
    addr_a_nxt       = addr_a_r;
    addr_b_nxt       = addr_b_r;
    wall_row_nxt     = wall_row_r;
    wall_col_nxt     = wall_col_r;
    label_a_nxt      = label_a_r;
    label_b_nxt      = label_b_r;
    scan_row_nxt     = scan_row_r;
    scan_col_nxt     = scan_col_r;
    scan_base_nxt    = scan_base_r;
    pipe_vld_nxt     = (state_r == S_SCAN);
    pipe_addr_nxt    = scan_addr;
    out_valid_nxt    = 1'b0;
    out_carved_nxt   = 1'b0;
    out_rejected_nxt = 1'b0;
    out_wall_row_nxt = '0;
    out_wall_col_nxt = '0;

    case (state_r)
      S_FILL: begin
        fill_addr_nxt = fill_addr_r + ADDR_W'(1);
        if (fill_addr_r == LAST_ADDR) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = fill_res_r;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_START) begin
            state_nxt     = S_FILL;
            fill_addr_nxt = '0;
            fill_res_nxt  = 1'b1;
          end else if (!in_grid) begin
            out_valid_nxt    = 1'b1;
            out_rejected_nxt = 1'b1;
          end else begin
            state_nxt    = S_RDA;
            addr_a_nxt   = in_addr_a;
            addr_b_nxt   = in_addr_b;
            wall_row_nxt = {1'b0, in_cell_row, 1'b0} + WALL_W'(1)
                           + WALL_W'(in_direction);
            wall_col_nxt = {1'b0, in_cell_col, 1'b0} + WALL_W'(2)
                           - WALL_W'(in_direction);
          end
        end
      end
      S_RDA: begin
        state_nxt = S_RDB;
      end
      S_RDB: begin
        label_a_nxt = mem_rdata;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (mem_rdata == label_a_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          label_b_nxt   = mem_rdata;
          scan_row_nxt  = '0;
          scan_col_nxt  = '0;
          scan_base_nxt = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last_col) begin
          scan_col_nxt  = '0;
          scan_row_nxt  = scan_row_r + RW'(1);
          scan_base_nxt = scan_base_r + ROW_STEP;
          if (scan_last_row) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          scan_col_nxt = scan_col_r + CW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt        = S_IDLE;
        out_valid_nxt    = 1'b1;
        out_carved_nxt   = 1'b1;
        out_wall_row_nxt = wall_row_r;
        out_wall_col_nxt = wall_col_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_addr_r <= '0;
      fill_res_r  <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_res_r  <= fill_res_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_a_r       <= addr_a_nxt;
    addr_b_r       <= addr_b_nxt;
    wall_row_r     <= wall_row_nxt;
    wall_col_r     <= wall_col_nxt;
    label_a_r      <= label_a_nxt;
    label_b_r      <= label_b_nxt;
    scan_row_r     <= scan_row_nxt;
    scan_col_r     <= scan_col_nxt;
    scan_base_r    <= scan_base_nxt;
    pipe_addr_r    <= pipe_addr_nxt;
    out_carved_r   <= out_carved_nxt;
    out_rejected_r <= out_rejected_nxt;
    out_wall_row_r <= out_wall_row_nxt;
    out_wall_col_r <= out_wall_col_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_carved   = out_carved_r;
  assign out_rejected = out_rejected_r;
  assign out_wall_row = out_wall_row_r;
  assign out_wall_col = out_wall_col_r;

endmodule

// ===== rtl/kruskal_maze_edge_merger.sv =====
// Kruskal maze edge merger top level: configuration registers, label RAM and sequencer.
// Depends on kme_pkg, kme_ram and kme_ctrl.
`timescale 1ns / 1ps

// One transaction is taken when start is high while busy is low; its single result
// appears for exactly one cycle with out_valid high and cannot be stalled. Labels sit
// in one RAM of MAX_ROWS*MAX_COLS entries with one write and one read per cycle, so
// timing is set by that port: a start transaction refills every entry before its
// result; an edge that leaves the grid gives its result the next cycle; an edge whose
// cells already share a label reads both labels and compares them; a carving edge scans
// the rows and columns in use at one cell per cycle and then gives its result. After
// reset the block runs the same fill pass with busy high; configuration writes are
// taken at any time.
module kruskal_maze_edge_merger #(
  parameter int MAX_ROWS = kme_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kme_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic [kme_pkg::ROW_W-1:0]      in_cell_row,
  input  logic [kme_pkg::COL_W-1:0]      in_cell_col,
  input  logic                           in_direction,
  output logic                           out_valid,
  output logic                           out_carved,
  output logic                           out_rejected,
  output logic [kme_pkg::WALL_W-1:0]     out_wall_row,
  output logic [kme_pkg::WALL_W-1:0]     out_wall_col,
  input  logic                           cfg_we,
  input  logic [kme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kme_pkg::CFG_W-1:0]      cfg_wdata
);

  import kme_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NRW    = $clog2(MAX_ROWS + 1);
  localparam int NCW    = $clog2(MAX_COLS + 1);
  localparam int RCMP_W = (NRW > CFG_W) ? NRW : CFG_W;
  localparam int CCMP_W = (NCW > CFG_W) ? NCW : CFG_W;

  logic [CFG_W-1:0]  rows_r, rows_nxt;
  logic [CFG_W-1:0]  cols_r, cols_nxt;
  logic [NRW-1:0]    num_rows;
  logic [NCW-1:0]    num_cols;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_rdata;

  // Configuration register writes.
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_nxt = cfg_wdata;
        REG_COLS: cols_nxt = cfg_wdata;
        default: begin
          rows_nxt = rows_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // Grid size in use: zero acts as one, anything above the maximum acts as the maximum.
  assign num_rows = (rows_r == '0) ? NRW'(1) :
                    ((RCMP_W'(rows_r) > RCMP_W'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_r));
  assign num_cols = (cols_r == '0) ? NCW'(1) :
                    ((CCMP_W'(cols_r) > CCMP_W'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_r));

  // Label store, one entry per cell.
  kme_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(DEPTH)
  ) u_label_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Sequencer.
  kme_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_cell_row (in_cell_row),
    .in_cell_col (in_cell_col),
    .in_direction(in_direction),
    .num_rows    (num_rows),
    .num_cols    (num_cols),
    .out_valid   (out_valid),
    .out_carved  (out_carved),
    .out_rejected(out_rejected),
    .out_wall_row(out_wall_row),
    .out_wall_col(out_wall_col),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule

// ===== dv/kme_carve_checker.sv =====
// Checker for the Kruskal maze edge merger: tracks the cell set labels, predicts each result.
// Depends on kme_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module kme_carve_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_operation,
  input  logic [kme_pkg::ROW_W-1:0]     in_cell_row,
  input  logic [kme_pkg::COL_W-1:0]     in_cell_col,
  input  logic                          in_direction,
  input  logic                          out_valid,
  input  logic                          out_carved,
  input  logic                          out_rejected,
  input  logic [kme_pkg::WALL_W-1:0]    out_wall_row,
  input  logic [kme_pkg::WALL_W-1:0]    out_wall_col,
  input  logic                          cfg_we,
  input  logic [kme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kme_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            outstanding,
  output int                            errors
);

  import kme_pkg::*;

  localparam int CELLS   = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int LABEL_W = $clog2(CELLS);

  typedef struct packed {
    logic              carved;
    logic              rejected;
    logic [WALL_W-1:0] wall_row;
    logic [WALL_W-1:0] wall_col;
  } wall_report_t;

  // Shadow copy of the block's label memory and grid registers.
  logic [LABEL_W-1:0] cell_set [CELLS];
  logic [CFG_W-1:0]   rows_reg;
  logic [CFG_W-1:0]   cols_reg;
  wall_report_t       awaited_walls [$];
  int                 mismatch_cnt = 0;

  // A register value of zero means one; anything above the maximum means the maximum.
  function automatic int unsigned in_use_extent(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void restart_sets();
    for (int k = 0; k < CELLS; k++) cell_set[k] = k[LABEL_W-1:0];
  endfunction

  // Apply one transaction to the shadow labels and return the report it must produce.
  function automatic wall_report_t carve_outcome(logic op, logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c, logic dir);
    wall_report_t       res;
    int unsigned        nr;
    int unsigned        nc;
    int unsigned        r2;
    int unsigned        c2;
    logic [LABEL_W-1:0] keep_set;
    logic [LABEL_W-1:0] gone_set;
    res = '0;
    nr = in_use_extent(rows_reg, MAX_ROWS_DEF);
    nc = in_use_extent(cols_reg, MAX_COLS_DEF);
    if (op == OP_START) begin
      restart_sets();
      return res;
    end
    r2 = int'(r) + ((dir == DIR_DOWN) ? 1 : 0);
    c2 = int'(c) + ((dir == DIR_RIGHT) ? 1 : 0);
    if (r >= nr || c >= nc || r2 >= nr || c2 >= nc) begin
      res.rejected = 1'b1;
      return res;
    end
    keep_set = cell_set[int'(r) * MAX_COLS_DEF + int'(c)];
    gone_set = cell_set[r2 * MAX_COLS_DEF + c2];
    if (keep_set != gone_set) begin
      // Only cells inside the grid in use are merged; the rest keep their labels.
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          if (cell_set[i * MAX_COLS_DEF + j] == gone_set) begin
            cell_set[i * MAX_COLS_DEF + j] = keep_set;
          end
        end
      end
      res.carved   = 1'b1;
      res.wall_row = WALL_W'(2 * int'(r) + 1 + int'(dir));
      res.wall_col = WALL_W'(2 * int'(c) + 2 - int'(dir));
    end
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Results are compared before a new transaction is queued; both are sampled at the edge.
  always @(posedge clk) begin
    wall_report_t want;
    if (!rst_n) begin
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      restart_sets();
      awaited_walls.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) begin
          rows_reg = cfg_wdata;
        end else if (cfg_index == REG_COLS) begin
          cols_reg = cfg_wdata;
        end
      end
      if (out_valid) begin
        if (awaited_walls.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0b %0b %0d %0d",
                   $time, out_carved, out_rejected, out_wall_row, out_wall_col);
          mismatch_cnt++;
        end else begin
          want = awaited_walls.pop_front();
          check_field("carved", want.carved, out_carved);
          check_field("rejected", want.rejected, out_rejected);
          check_field("wall_row", want.wall_row, out_wall_row);
          check_field("wall_col", want.wall_col, out_wall_col);
        end
      end
      if (start && !busy) begin
        awaited_walls.insert(awaited_walls.size(),
                             carve_outcome(in_operation, in_cell_row, in_cell_col,
                                           in_direction));
      end
    end
    outstanding <= awaited_walls.size();
    errors      <= mismatch_cnt;
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the maze edge merger testbench: clock, reset, directed and random transactions.
// Depends on kme_pkg, kruskal_maze_edge_merger and kme_carve_checker.
`timescale 1ns / 1ps

module tb_top;
  import kme_pkg::*;

  localparam int TOTAL_ITEMS = 580;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             dir;
  } maze_edge_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic                 in_operation = 1'b0;
  logic [ROW_W-1:0]     in_cell_row  = '0;
  logic [COL_W-1:0]     in_cell_col  = '0;
  logic                 in_direction = 1'b0;
  logic                 out_valid;
  logic                 out_carved;
  logic                 out_rejected;
  logic [WALL_W-1:0]    out_wall_row;
  logic [WALL_W-1:0]    out_wall_col;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_wdata    = '0;
  int                   outstanding;
  int                   errors;
  int                   items_sent   = 0;

  kruskal_maze_edge_merger DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_direction (in_direction),
    .out_valid    (out_valid),
    .out_carved   (out_carved),
    .out_rejected (out_rejected),
    .out_wall_row (out_wall_row),
    .out_wall_col (out_wall_col),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  kme_carve_checker carve_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_direction (in_direction),
    .out_valid    (out_valid),
    .out_carved   (out_carved),
    .out_rejected (out_rejected),
    .out_wall_row (out_wall_row),
    .out_wall_col (out_wall_col),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .outstanding  (outstanding),
    .errors       (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Present one transaction and hold it until the block takes it. Start is left high so
  // that back-to-back transactions need no second assignment in one step.
  task automatic send_item(logic op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c, logic dir);
    bit gaps_on;
    gaps_on = !(items_sent >= 250 && items_sent < 370);
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 1100) : $urandom_range(1, 12))
        @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_cell_row  <= r;
    in_cell_col  <= c;
    in_direction <= dir;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Stop sending and wait until every expected result has come back and the block is idle.
  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // Change the grid size; only done while the block is idle.
  task automatic program_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    bit cols_first;
    cols_first = $urandom_range(0, 1);
    wait_for_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= cols_first ? REG_COLS : REG_ROWS;
    cfg_wdata <= cols_first ? cols : rows;
    @(posedge clk);
    cfg_index <= cols_first ? REG_ROWS : REG_COLS;
    cfg_wdata <= cols_first ? rows : cols;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    maze_edge_t       walls [$];
    maze_edge_t       tmp;
    logic [CFG_W-1:0] rows_val;
    logic [CFG_W-1:0] cols_val;
    int unsigned      nr;
    int unsigned      nc;
    int unsigned      budget;
    int unsigned      pick;
    int               j;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Full grid: corner cells, chained merges, a same-set edge and edges off the grid.
    program_grid(6'd32, 6'd32);
    send_item(OP_EDGE, 5'd0, 5'd0, DIR_RIGHT);
    send_item(OP_EDGE, 5'd0, 5'd0, DIR_DOWN);
    send_item(OP_EDGE, 5'd0, 5'd1, DIR_DOWN);
    send_item(OP_EDGE, 5'd1, 5'd0, DIR_RIGHT);
    send_item(OP_EDGE, 5'd31, 5'd31, DIR_RIGHT);
    send_item(OP_EDGE, 5'd31, 5'd31, DIR_DOWN);
    send_item(OP_EDGE, 5'd31, 5'd30, DIR_RIGHT);
    send_item(OP_EDGE, 5'd30, 5'd31, DIR_DOWN);
    send_item(OP_EDGE, 5'd0, 5'd2, DIR_RIGHT);

    // Narrow the grid so a merge leaves a relabeled set member outside it untouched.
    program_grid(6'd32, 6'd3);
    send_item(OP_EDGE, 5'd0, 5'd1, DIR_RIGHT);
    send_item(OP_EDGE, 5'd0, 5'd2, DIR_RIGHT);

    // Values above the maximum act as the maximum; the cell outside must still differ.
    program_grid(6'd63, 6'd33);
    send_item(OP_EDGE, 5'd0, 5'd2, DIR_RIGHT);
    send_item(OP_START, 5'd31, 5'd31, DIR_DOWN);
    send_item(OP_EDGE, 5'd0, 5'd0, DIR_RIGHT);

    // Zero rows acts as a single row.
    program_grid(6'd0, 6'd63);
    send_item(OP_EDGE, 5'd0, 5'd5, DIR_DOWN);
    send_item(OP_EDGE, 5'd0, 5'd30, DIR_RIGHT);
    send_item(OP_EDGE, 5'd0, 5'd31, DIR_RIGHT);

    // Zero columns acts as a single column.
    program_grid(6'd63, 6'd0);
    send_item(OP_EDGE, 5'd5, 5'd0, DIR_DOWN);
    send_item(OP_EDGE, 5'd5, 5'd0, DIR_RIGHT);
    send_item(OP_EDGE, 5'd31, 5'd0, DIR_DOWN);

    // A one-cell maze rejects every edge.
    program_grid(6'd1, 6'd1);
    send_item(OP_EDGE, 5'd0, 5'd0, DIR_RIGHT);
    send_item(OP_EDGE, 5'd0, 5'd0, DIR_DOWN);
    send_item(OP_START, 5'd0, 5'd0, DIR_RIGHT);

    // Random mazes: each episode picks a grid, usually restarts, then offers the edges of
    // that grid in shuffled order with some stray transactions mixed in.
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        rows_val = $urandom_range(0, 1) ? CFG_W'(32) : CFG_W'($urandom_range(33, 63));
        cols_val = $urandom_range(0, 1) ? CFG_W'(32) : CFG_W'($urandom_range(33, 63));
      end else if (pick <= 3) begin
        if ($urandom_range(0, 1)) begin
          rows_val = CFG_W'($urandom_range(1, 2));
          cols_val = CFG_W'(32);
        end else begin
          rows_val = CFG_W'(32);
          cols_val = CFG_W'($urandom_range(1, 2));
        end
      end else begin
        rows_val = CFG_W'($urandom_range(0, 8));
        cols_val = CFG_W'($urandom_range(0, 8));
      end
      program_grid(rows_val, cols_val);
      nr = (rows_val == 0) ? 1 : ((rows_val > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_val);
      nc = (cols_val == 0) ? 1 : ((cols_val > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_val);

      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_START, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
      end

      // Every interior wall of the grid, then a shuffle.
      walls.delete();
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          if (c + 1 < nc) walls.insert(walls.size(), {5'(r), 5'(c), DIR_RIGHT});
          if (r + 1 < nr) walls.insert(walls.size(), {5'(r), 5'(c), DIR_DOWN});
        end
      end
      for (int i = walls.size() - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = walls[i];
        walls[i] = walls[j];
        walls[j] = tmp;
      end
      budget = (pick == 0) ? 8 : walls.size() + walls.size() / 5 + 4;

      for (int unsigned k = 0; k < budget && items_sent < TOTAL_ITEMS; k++) begin
        if (walls.size() == 0 || $urandom_range(0, 99) < 15) begin
          // Stray transaction, often just past the grid boundary.
          if ($urandom_range(0, 1)) begin
            send_item(($urandom_range(0, 24) == 0) ? OP_START : OP_EDGE,
                      ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)));
          end else begin
            send_item(OP_EDGE, ROW_W'($urandom_range(0, (nr > 31) ? 31 : nr)),
                      COL_W'($urandom_range(0, (nc > 31) ? 31 : nc)),
                      1'($urandom_range(0, 1)));
          end
        end else begin
          tmp = walls.pop_front();
          send_item(OP_EDGE, tmp.row, tmp.col, tmp.dir);
        end
        if ($urandom_range(0, 49) == 0) wait_for_quiet();
      end
    end

    // Let the last results drain, then give the verdict.
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
